>>> hw/rtl/alsim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package alsim_pkg;

  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ALLELE_W   = 8;
  localparam int SIM_W      = 17;
  localparam int OUT_CNT_W  = 32;
  localparam int STEP_W     = $clog2(FRAC_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(FRAC_BITS);

  typedef struct packed {
    logic acc;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  typedef enum logic [1:0] {
    ST_ACC = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  // homozygote-aware match count of one diploid locus
  function automatic logic [1:0] pair_matches(input logic [ALLELE_W-1:0] p,
                                              input logic [ALLELE_W-1:0] q,
                                              input logic [ALLELE_W-1:0] r,
                                              input logic [ALLELE_W-1:0] s);
    logic [2:0] sum;
    sum = '0;
    if (p == q) begin
      sum = 3'(p == r) + 3'(p == s);
    end else if (r == s) begin
      sum = 3'(r == p) + 3'(r == q);
    end else begin
      sum = 3'(p == r) + 3'(p == s) + 3'(q == r) + 3'(q == s);
    end
    return sum[1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/allele_sharing_similarity_core.sv
// out_tvalid rises once the divider is done after the last item and the output register is free
// throughput: one locus item per cycle, then in_tready is low for each pair
// while the shared compare-subtract divider produces one quotient bit per cycle
// the output register lets the next pair stream in while a result waits
// reset (rst_n low, synchronous): counters cleared, diploid_mode set to 1, no result held
`timescale 1ns / 1ps
`default_nettype none
module allele_sharing_similarity_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // diploid_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // x_allele_first, x_allele_second,
                                          // y_allele_first, y_allele_second
  input  wire logic        in_tlast,      // last_locus
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,     // similarity, called_alleles, shared_alleles, zero fill
  output logic             out_tuser      // no_data
);

  alsim_pkg::cmd_t                   cmd;
  alsim_pkg::stat_t                  stat;
  logic [alsim_pkg::SIM_W-1:0]       similarity;
  logic [alsim_pkg::OUT_CNT_W-1:0]   called_alleles;
  logic [alsim_pkg::OUT_CNT_W-1:0]   shared_alleles;

  alsim_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  alsim_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .x_allele_first  (in_tdata[7:0]),
    .x_allele_second (in_tdata[15:8]),
    .y_allele_first  (in_tdata[23:16]),
    .y_allele_second (in_tdata[31:24]),
    .cmd             (cmd),
    .stat            (stat),
    .similarity      (similarity),
    .called_alleles  (called_alleles),
    .shared_alleles  (shared_alleles),
    .no_data         (out_tuser)
  );

  assign out_tdata = {7'd0, shared_alleles, called_alleles, similarity};

endmodule
`default_nettype wire

>>> hw/rtl/alsim_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module alsim_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tlast,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output alsim_pkg::cmd_t       cmd,
  input  wire alsim_pkg::stat_t stat
);

  alsim_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              accept;

  assign in_tready  = (state_r == alsim_pkg::ST_ACC);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.acc      = accept;
    cmd.start    = accept && in_tlast;
    unique case (state_r)
      alsim_pkg::ST_ACC: begin
        if (cmd.start) begin
          state_nxt = alsim_pkg::ST_DIV;
        end
      end
      alsim_pkg::ST_DIV: begin
        if (!stat.div_done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = alsim_pkg::ST_ACC;
        end
      end
      default: state_nxt = alsim_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alsim_pkg::ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/alsim_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module alsim_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic                             cfg_wr_data,
  input  wire logic [alsim_pkg::ALLELE_W-1:0]   x_allele_first,
  input  wire logic [alsim_pkg::ALLELE_W-1:0]   x_allele_second,
  input  wire logic [alsim_pkg::ALLELE_W-1:0]   y_allele_first,
  input  wire logic [alsim_pkg::ALLELE_W-1:0]   y_allele_second,
  input  wire alsim_pkg::cmd_t                  cmd,
  output alsim_pkg::stat_t                      stat,
  output logic [alsim_pkg::SIM_W-1:0]           similarity,
  output logic [alsim_pkg::OUT_CNT_W-1:0]       called_alleles,
  output logic [alsim_pkg::OUT_CNT_W-1:0]       shared_alleles,
  output logic                                  no_data
);

  logic                               diploid_r;
  logic [alsim_pkg::COUNT_BITS-1:0]   called_r, called_nxt;
  logic [alsim_pkg::COUNT_BITS-1:0]   shared_r, shared_nxt;
  logic [alsim_pkg::COUNT_BITS-1:0]   called_sum, shared_sum;
  logic [1:0]                         called_inc, shared_inc;
  logic [alsim_pkg::COUNT_BITS-1:0]   den_r, num_r;
  logic [alsim_pkg::COUNT_BITS:0]     rem_r, rem_nxt, rem_shl;
  logic [alsim_pkg::FRAC_BITS-1:0]    quo_r, quo_nxt;
  logic [alsim_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                               full_r, empty_r;
  logic                               ge;
  logic [alsim_pkg::SIM_W-1:0]        sim_r;
  logic [alsim_pkg::OUT_CNT_W-1:0]    out_called_r, out_shared_r;
  logic                               nodata_r;

  function automatic logic [alsim_pkg::COUNT_BITS-1:0] sat_add(
    input logic [alsim_pkg::COUNT_BITS-1:0] a,
    input logic [1:0]                       b
  );
    logic [alsim_pkg::COUNT_BITS:0] s;
    s = {1'b0, a} + (alsim_pkg::COUNT_BITS + 1)'(b);
    return s[alsim_pkg::COUNT_BITS] ? alsim_pkg::COUNT_MAX : s[alsim_pkg::COUNT_BITS-1:0];
  endfunction

  // per-locus increments
  always_comb begin
    called_inc = 2'd0;
    shared_inc = 2'd0;
    if (diploid_r) begin
      if ((x_allele_first != '0) && (x_allele_second != '0) &&
          (y_allele_first != '0) && (y_allele_second != '0)) begin
        called_inc = 2'd2;
        shared_inc = alsim_pkg::pair_matches(x_allele_first, x_allele_second,
                                             y_allele_first, y_allele_second);
      end
    end else begin
      if ((x_allele_first != '0) && (y_allele_first != '0)) begin
        called_inc = 2'd1;
        shared_inc = 2'(x_allele_first == y_allele_first);
      end
    end
  end

  assign called_sum = sat_add(called_r, called_inc);
  assign shared_sum = sat_add(shared_r, shared_inc);

  always_comb begin
    called_nxt = called_r;
    shared_nxt = shared_r;
    if (cmd.start) begin
      called_nxt = '0;
      shared_nxt = '0;
    end else if (cmd.acc) begin
      called_nxt = called_sum;
      shared_nxt = shared_sum;
    end
  end

  // restoring long division, one quotient bit per step
  assign rem_shl = {rem_r[alsim_pkg::COUNT_BITS-1:0], 1'b0};
  assign ge      = (rem_shl >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    if (cmd.start) begin
      rem_nxt  = {1'b0, shared_sum};
      quo_nxt  = '0;
      step_nxt = '0;
    end else if (cmd.step) begin
      rem_nxt  = ge ? (rem_shl - {1'b0, den_r}) : rem_shl;
      quo_nxt  = {quo_r[alsim_pkg::FRAC_BITS-2:0], ge};
      step_nxt = step_r + 1'b1;
    end
  end

  assign stat.div_done = (step_r == alsim_pkg::STEP_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diploid_r <= 1'b1;
      called_r  <= '0;
      shared_r  <= '0;
      step_r    <= alsim_pkg::STEP_LAST;
    end else begin
      if (cfg_wr_en) begin
        diploid_r <= cfg_wr_data;
      end
      called_r <= called_nxt;
      shared_r <= shared_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.start) begin
      den_r   <= called_sum;
      num_r   <= shared_sum;
      full_r  <= (shared_sum >= called_sum);
      empty_r <= (called_sum == '0);
    end
    if (cmd.load_out) begin
      if (empty_r) begin
        sim_r <= '0;
      end else if (full_r) begin
        sim_r <= alsim_pkg::SIM_W'(1) << alsim_pkg::FRAC_BITS;
      end else begin
        sim_r <= alsim_pkg::SIM_W'(quo_r);
      end
      out_called_r <= alsim_pkg::OUT_CNT_W'(den_r);
      out_shared_r <= alsim_pkg::OUT_CNT_W'(num_r);
      nodata_r     <= empty_r;
    end
  end

  assign similarity     = sim_r;
  assign called_alleles = out_called_r;
  assign shared_alleles = out_shared_r;
  assign no_data        = nodata_r;

endmodule
`default_nettype wire

>>> hw/rtl/alsim_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module alsim_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tuser
);

  // divider busy after the last item of a pair
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("item accepted while divider busy");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[16:0] == 17'd0) && (out_tdata[48:17] == 32'd0))
    else $error("no_data with nonzero similarity or count");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= (17'd1 << alsim_pkg::FRAC_BITS)) &&
                   (out_tdata[80:49] <= out_tdata[48:17]))
    else $error("similarity or shared count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind allele_sharing_similarity_core alsim_chk u_alsim_chk (.*);
`default_nettype wire
